@@ hdl/hcbd_pkg.sv @@
package hcbd_pkg;

  // Chunk size register width; the oversize check follows from it.
  localparam int LENGTH_BITS = 24;
  localparam int TOTAL_W     = 24;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_C  = 8'h63;

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_RAW     = 2'd2,
    KIND_PAYLOAD = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_DONE    = 3'd1,
    ST_ERROR   = 3'd2,
    ST_BOUNDARY = 3'd3,
    ST_RAW     = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    kind_t              out_kind;
    status_t            msg_status;
    logic [TOTAL_W-1:0] decoded_total;
  } out_item_t;

  // Header matcher results for one byte.
  typedef struct packed {
    logic [2:0] word_match;
    logic [1:0] end_match;
    logic       chunked_seen;
    logic       hdr_end;
  } hdr_scan_t;

endpackage

@@ hdl/http_chunked_body_decoder_core.sv @@
// Decodes an HTTP response arriving one byte per transfer: header bytes pass
// through until CR LF CR LF, and a body whose header named "chunked" is
// de-chunked when decode_enable is set (sampled at the header end), otherwise
// passed raw. One result comes out per input byte, at a sustained rate of one
// byte per clock while out_stall is low. A byte is captured in the input
// register, and its result, formed combinationally from that byte and the
// decoder state, is loaded into the result register when the output is not
// stalled; the decoder state is updated at the same edge.
// Write cfg_wdata only while no response bytes are in flight.
module http_chunked_body_decoder_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hcbd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hcbd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import hcbd_pkg::*;

  in_item_t  in_r;
  logic      in_v_r;
  out_item_t out_r;
  logic      out_v_r;
  logic      decode_enable_r;

  out_item_t result;
  logic      out_ready;
  logic      adv;
  logic      in_take;

  assign out_ready = !out_v_r || !out_stall;
  assign adv       = in_v_r && out_ready;
  assign in_stall  = in_v_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  hcbd_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .item          (in_r),
    .decode_enable (decode_enable_r),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r          <= 1'b0;
      out_v_r         <= 1'b0;
      decode_enable_r <= 1'b1;
    end else begin
      in_v_r <= in_take || (in_v_r && !adv);
      if (out_ready) out_v_r <= adv;
      if (cfg_we) decode_enable_r <= cfg_wdata;
    end
  end

  // Payload registers hold while stalled.
  always_ff @(posedge clk) begin
    if (in_take) in_r <= in_data;
    if (adv) out_r <= result;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

@@ hdl/hcbd_hdr_scan.sv @@
module hcbd_hdr_scan (
  input  logic [7:0]        in_byte,
  input  logic [2:0]        word_match,
  input  logic [1:0]        end_match,
  input  logic              chunked_seen,
  output hcbd_pkg::hdr_scan_t scan
);
  import hcbd_pkg::*;

  function automatic logic [7:0] word_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h63; // c
      3'd1:    ch = 8'h68; // h
      3'd2:    ch = 8'h75; // u
      3'd3:    ch = 8'h6e; // n
      3'd4:    ch = 8'h6b; // k
      3'd5:    ch = 8'h65; // e
      3'd6:    ch = 8'h64; // d
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  logic [7:0] end_char;

  // Header end is CR LF CR LF: even positions want CR, odd want LF.
  assign end_char = end_match[0] ? CHAR_LF : CHAR_CR;

  always_comb begin
    scan.chunked_seen = chunked_seen;
    scan.hdr_end      = 1'b0;

    if (in_byte == word_char(word_match)) begin
      if (word_match == 3'd6) begin
        scan.chunked_seen = 1'b1;
        scan.word_match   = 3'd0;
      end else begin
        scan.word_match = word_match + 3'd1;
      end
    end else begin
      scan.word_match = (in_byte == CHAR_C) ? 3'd1 : 3'd0;
    end

    if (in_byte == end_char) begin
      if (end_match == 2'd3) begin
        scan.end_match = 2'd0;
        scan.hdr_end   = 1'b1;
      end else begin
        scan.end_match = end_match + 2'd1;
      end
    end else begin
      scan.end_match = (in_byte == CHAR_CR) ? 2'd1 : 2'd0;
    end
  end

endmodule

@@ hdl/hcbd_step.sv @@
module hcbd_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  hcbd_pkg::in_item_t  item,
  input  logic                decode_enable,
  output hcbd_pkg::out_item_t result
);
  import hcbd_pkg::*;

  typedef enum logic [3:0] {
    PH_HDR     = 4'd0,
    PH_RAW     = 4'd1,
    PH_SIZE0   = 4'd2,
    PH_SIZE    = 4'd3,
    PH_SIZE_LF = 4'd4,
    PH_DATA    = 4'd5,
    PH_DATA_CR = 4'd6,
    PH_DATA_LF = 4'd7,
    PH_DONE    = 4'd8,
    PH_ERR     = 4'd9
  } phase_t;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    else r = 5'd0;
    return r;
  endfunction

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             word_match_r;
  logic [1:0]             end_match_r;
  logic                   chunked_seen_r;
  logic [LENGTH_BITS-1:0] size_accum_r, size_accum_nxt;
  logic [LENGTH_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [TOTAL_W-1:0]     payload_count_r, payload_count_nxt;

  hdr_scan_t  scan;
  logic [4:0] hex;
  logic       size_ovf;
  kind_t      kind;
  status_t    status;

  hcbd_hdr_scan u_hdr_scan (
    .in_byte      (item.in_byte),
    .word_match   (word_match_r),
    .end_match    (end_match_r),
    .chunked_seen (chunked_seen_r),
    .scan         (scan)
  );

  assign hex      = hex_value(item.in_byte);
  // Shifting in one more digit would exceed the size range.
  assign size_ovf = |size_accum_r[LENGTH_BITS-1 -: 4];

  always_comb begin
    phase_nxt         = phase_r;
    size_accum_nxt    = size_accum_r;
    bytes_left_nxt    = bytes_left_r;
    payload_count_nxt = payload_count_r;
    kind              = KIND_FRAME;

    case (phase_r)
      PH_HDR: begin
        kind = KIND_HEADER;
        if (scan.hdr_end) begin
          phase_nxt = (decode_enable && scan.chunked_seen) ? PH_SIZE0 : PH_RAW;
        end
      end
      PH_RAW: begin
        kind = KIND_RAW;
      end
      PH_SIZE0, PH_SIZE: begin
        if (hex[4]) begin
          size_accum_nxt = {size_accum_r[LENGTH_BITS-5:0], hex[3:0]};
          phase_nxt      = size_ovf ? PH_ERR : PH_SIZE;
        end else if (item.in_byte == CHAR_CR) begin
          phase_nxt = PH_SIZE_LF;
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_SIZE_LF: begin
        if (item.in_byte == CHAR_LF) begin
          if (size_accum_r == '0) begin
            phase_nxt = PH_DONE;
          end else begin
            bytes_left_nxt = size_accum_r;
            size_accum_nxt = '0;
            phase_nxt      = PH_DATA;
          end
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_DATA: begin
        kind = KIND_PAYLOAD;
        if (payload_count_r != TOTAL_MAX) payload_count_nxt = payload_count_r + 1'b1;
        if (bytes_left_r != '0) bytes_left_nxt = bytes_left_r - 1'b1;
        if (bytes_left_nxt == '0) phase_nxt = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        phase_nxt = (item.in_byte == CHAR_CR) ? PH_DATA_LF : PH_ERR;
      end
      PH_DATA_LF: begin
        phase_nxt = (item.in_byte == CHAR_LF) ? PH_SIZE0 : PH_ERR;
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_ERR;
      end
    endcase

    if (phase_nxt == PH_RAW) status = ST_RAW;
    else if (phase_nxt == PH_DONE) status = ST_DONE;
    else if (phase_nxt == PH_ERR) status = ST_ERROR;
    else if (item.in_last) begin
      if (phase_nxt == PH_HDR) status = ST_RAW;
      else if (phase_nxt == PH_SIZE0) status = ST_BOUNDARY;
      else status = ST_ERROR;
    end else begin
      status = ST_RUN;
    end
  end

  assign result.out_byte      = item.in_byte;
  assign result.out_kind      = kind;
  assign result.msg_status    = status;
  assign result.decoded_total = payload_count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && item.in_last)) begin
      // Last byte of a response: start the next one from scratch.
      phase_r         <= PH_HDR;
      word_match_r    <= 3'd0;
      end_match_r     <= 2'd0;
      chunked_seen_r  <= 1'b0;
      size_accum_r    <= '0;
      bytes_left_r    <= '0;
      payload_count_r <= '0;
    end else if (adv) begin
      phase_r         <= phase_nxt;
      size_accum_r    <= size_accum_nxt;
      bytes_left_r    <= bytes_left_nxt;
      payload_count_r <= payload_count_nxt;
      if (phase_r == PH_HDR) begin
        word_match_r   <= scan.word_match;
        end_match_r    <= scan.end_match;
        chunked_seen_r <= scan.chunked_seen;
      end
    end
  end

endmodule

@@ hdl/hcbd_checker.sv @@
module hcbd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input hcbd_pkg::out_item_t out_data
);
  import hcbd_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // No payload is counted before the header has ended.
  a_hdr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == KIND_HEADER |-> out_data.decoded_total == '0)
    else $error("header byte with nonzero payload count");

  // A payload byte is counted and reports run, or error if the response ends inside the chunk.
  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == KIND_PAYLOAD |->
      out_data.decoded_total != '0 &&
      (out_data.msg_status == ST_RUN || out_data.msg_status == ST_ERROR))
    else $error("payload byte with bad count or status");

  // Raw body bytes always report not decoded.
  a_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == KIND_RAW |-> out_data.msg_status == ST_RAW)
    else $error("raw body byte with wrong status");

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (.*);
